// ----- rtl/core/stmc_pkg.sv -----
package stmc_pkg;

    localparam int QUOT_W  = 12;
    localparam int SENS_W  = 15;
    localparam int CFG12_W = 12;
    localparam int TIME_W  = 16;
    localparam int DUTY_W  = 13;
    localparam int MODE_W  = 3;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 3;

    // A 15-bit sample divided by ten: multiply by ceil(2^19 / 10) and keep the top bits.
    localparam logic [TIME_W-1:0] DIV10_MUL   = 16'hCCCD;
    localparam int                DIV10_SHIFT = 19;
    localparam int                PROD_W      = SENS_W + TIME_W;

    localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE   = 3'd0,
        MODE_SUNNY  = 3'd1,
        MODE_TRACK  = 3'd2,
        MODE_POST   = 3'd3,
        MODE_WAIT   = 3'd4,
        MODE_RETURN = 3'd5,
        MODE_MANUAL = 3'd6
    } mode_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_SUN_OFFSET    = 3'd0,
        REG_SUN_THRESHOLD = 3'd1,
        REG_DEADBAND      = 3'd2,
        REG_SETTLE_MS     = 3'd3,
        REG_LOW_SUN_MS    = 3'd4,
        REG_TRACK_MS      = 3'd5,
        REG_POST_TRACK_MS = 3'd6,
        REG_RETURN_MS     = 3'd7
    } reg_index_t;

    localparam logic [CFG12_W-1:0] RST_SUN_OFFSET    = 12'd2580;
    localparam logic [CFG12_W-1:0] RST_SUN_THRESHOLD = 12'd20;
    localparam logic [CFG12_W-1:0] RST_DEADBAND      = 12'd10;
    localparam logic [TIME_W-1:0]  RST_SETTLE_MS     = 16'd5000;
    localparam logic [TIME_W-1:0]  RST_LOW_SUN_MS    = 16'd5000;
    localparam logic [TIME_W-1:0]  RST_TRACK_MS      = 16'd15000;
    localparam logic [TIME_W-1:0]  RST_POST_TRACK_MS = 16'd5000;
    localparam logic [TIME_W-1:0]  RST_RETURN_MS     = 16'd20000;

    typedef struct packed {
        logic [CFG12_W-1:0] sun_offset;
        logic [CFG12_W-1:0] sun_threshold;
        logic [CFG12_W-1:0] deadband;
        logic [TIME_W-1:0]  settle_ms;
        logic [TIME_W-1:0]  low_sun_ms;
        logic [TIME_W-1:0]  track_ms;
        logic [TIME_W-1:0]  post_track_ms;
        logic [TIME_W-1:0]  return_ms;
    } cfg_t;

    // One tick after the divide: scaled sensor readings and the button levels.
    typedef struct packed {
        logic [QUOT_W-1:0] quot_one;
        logic [QUOT_W-1:0] quot_two;
        logic              button_fwd;
        logic              button_rev;
        logic              manual_toggle;
    } item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] drive_one;
        logic [DUTY_W-1:0] drive_two;
        mode_t             mode;
    } result_t;

endpackage

// ----- rtl/core/stmc_ctrl.sv -----
module stmc_ctrl #(
    parameter logic [stmc_pkg::DUTY_W-1:0] TRACK_DUTY  = 13'd5000,
    parameter logic [stmc_pkg::DUTY_W-1:0] MANUAL_DUTY = 13'd7000
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  stmc_pkg::item_t   item,
    input  stmc_pkg::cfg_t    cfg,
    output stmc_pkg::result_t result
);

    stmc_pkg::mode_t                mode_reg;
    stmc_pkg::mode_t                mode_next;
    logic [stmc_pkg::TIME_W-1:0]    elapsed_reg;
    logic [stmc_pkg::TIME_W-1:0]    elapsed_next;
    logic [stmc_pkg::TIME_W-1:0]    elapsed_up;
    logic [stmc_pkg::DUTY_W-1:0]    drive_one;
    logic [stmc_pkg::DUTY_W-1:0]    drive_two;
    logic                           sunny;
    logic                           one_brighter;
    logic [stmc_pkg::QUOT_W-1:0]    diff_mag;
    logic                           outside_band;

    // Sun level offset - q1 above threshold, rearranged so that nothing goes negative.
    assign sunny = {1'b0, cfg.sun_offset} >
                   ({1'b0, item.quot_one} + {1'b0, cfg.sun_threshold});

    assign one_brighter = item.quot_one >= item.quot_two;
    assign diff_mag     = one_brighter ? item.quot_one - item.quot_two
                                       : item.quot_two - item.quot_one;
    assign outside_band = diff_mag > cfg.deadband;

    assign elapsed_up = (elapsed_reg == stmc_pkg::TIME_MAX) ? elapsed_reg
                                                            : elapsed_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= stmc_pkg::MODE_IDLE;
            elapsed_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        elapsed_next = elapsed_up;
        drive_one    = '0;
        drive_two    = '0;
        if (item.manual_toggle)
        begin
            mode_next    = (mode_reg == stmc_pkg::MODE_MANUAL) ? stmc_pkg::MODE_IDLE
                                                               : stmc_pkg::MODE_MANUAL;
            elapsed_next = '0;
        end
        else
        begin
            case (mode_reg)
                stmc_pkg::MODE_IDLE:
                begin
                    mode_next    = sunny ? stmc_pkg::MODE_SUNNY : stmc_pkg::MODE_WAIT;
                    elapsed_next = '0;
                end
                stmc_pkg::MODE_SUNNY:
                begin
                    if (elapsed_reg >= cfg.settle_ms)
                    begin
                        mode_next    = sunny ? stmc_pkg::MODE_TRACK : stmc_pkg::MODE_IDLE;
                        elapsed_next = '0;
                    end
                end
                stmc_pkg::MODE_TRACK:
                begin
                    if (elapsed_reg >= cfg.track_ms)
                    begin
                        mode_next    = stmc_pkg::MODE_POST;
                        elapsed_next = '0;
                    end
                    else if (outside_band)
                    begin
                        if (one_brighter)
                            drive_one = TRACK_DUTY;
                        else
                            drive_two = TRACK_DUTY;
                    end
                end
                stmc_pkg::MODE_POST:
                begin
                    if (elapsed_reg >= cfg.post_track_ms)
                    begin
                        mode_next    = stmc_pkg::MODE_IDLE;
                        elapsed_next = '0;
                    end
                end
                stmc_pkg::MODE_WAIT:
                begin
                    if (sunny)
                    begin
                        mode_next    = stmc_pkg::MODE_IDLE;
                        elapsed_next = '0;
                    end
                    else if (elapsed_reg >= cfg.low_sun_ms)
                    begin
                        mode_next    = stmc_pkg::MODE_RETURN;
                        elapsed_next = '0;
                    end
                end
                stmc_pkg::MODE_RETURN:
                begin
                    if (elapsed_reg >= cfg.return_ms)
                    begin
                        mode_next    = stmc_pkg::MODE_IDLE;
                        elapsed_next = '0;
                    end
                    else
                        drive_two = TRACK_DUTY;
                end
                stmc_pkg::MODE_MANUAL:
                begin
                    // The timer is frozen while under manual control.
                    elapsed_next = elapsed_reg;
                    if (item.button_fwd)
                        drive_one = MANUAL_DUTY;
                    else if (item.button_rev)
                        drive_two = MANUAL_DUTY;
                end
                default:
                begin
                    mode_next    = stmc_pkg::MODE_IDLE;
                    elapsed_next = '0;
                end
            endcase
        end
    end

    assign result.drive_one = drive_one;
    assign result.drive_two = drive_two;
    assign result.mode      = mode_next;

`ifndef ASSERT_OFF
    a_manual_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !item.manual_toggle && mode_reg == stmc_pkg::MODE_MANUAL)
        |=> (mode_reg == stmc_pkg::MODE_MANUAL))
        else $error("manual mode left without a toggle");

    a_toggle_leaves_manual: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.manual_toggle && mode_reg == stmc_pkg::MODE_MANUAL)
        |=> (mode_reg == stmc_pkg::MODE_IDLE && elapsed_reg == '0))
        else $error("toggle from manual did not return to idle with a cleared timer");

    a_timer_held: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(elapsed_reg) && $stable(mode_reg))
        else $error("mode state moved without a transaction");
`endif

endmodule

// ----- rtl/core/solar_tracker_mode_controller.sv -----
// Channel  Handshake             Payload
// -------  --------------------  ------------------------------------------------
// in       in_valid / in_stall   sensor_one, sensor_two, button_fwd, button_rev,
//                                manual_toggle
// out      out_valid / out_stall drive_one, drive_two, mode
// cfg      cfg_we                cfg_index, cfg_data
//
// The samples of each transaction are divided by ten into the input register, and the
// mode machine then fills the result register from it once that register is free.
// One transaction is taken every cycle while the result register drains.
// Reset defaults the config, clears valid flags, and idles the machine with a zero timer.
// A stall on out backs up into in_stall only once both registers hold a transaction.
module solar_tracker_mode_controller #(
    parameter logic [12:0] TRACK_DUTY  = 13'd5000,
    parameter logic [12:0] MANUAL_DUTY = 13'd7000
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [stmc_pkg::SENS_W-1:0]     sensor_one,
    input  logic [stmc_pkg::SENS_W-1:0]     sensor_two,
    input  logic                            button_fwd,
    input  logic                            button_rev,
    input  logic                            manual_toggle,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [stmc_pkg::DUTY_W-1:0]     drive_one,
    output logic [stmc_pkg::DUTY_W-1:0]     drive_two,
    output logic [stmc_pkg::MODE_W-1:0]     mode,
    input  logic                            cfg_we,
    input  logic [stmc_pkg::INDEX_W-1:0]    cfg_index,
    input  logic [stmc_pkg::CFG_W-1:0]      cfg_data
);

    stmc_pkg::cfg_t                     cfg_reg;
    stmc_pkg::item_t                    item_reg;
    stmc_pkg::item_t                    item_next;
    stmc_pkg::result_t                  result_reg;
    stmc_pkg::result_t                  result_next;
    logic                               item_valid_reg;
    logic                               out_valid_reg;
    logic                               out_free;
    logic                               advance;
    logic                               in_accept;
    logic [stmc_pkg::PROD_W-1:0]        prod_one;
    logic [stmc_pkg::PROD_W-1:0]        prod_two;

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = item_valid_reg && out_free;
    assign in_stall  = item_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    assign prod_one = stmc_pkg::PROD_W'(sensor_one) * stmc_pkg::PROD_W'(stmc_pkg::DIV10_MUL);
    assign prod_two = stmc_pkg::PROD_W'(sensor_two) * stmc_pkg::PROD_W'(stmc_pkg::DIV10_MUL);

    assign item_next.quot_one      = prod_one[stmc_pkg::DIV10_SHIFT +: stmc_pkg::QUOT_W];
    assign item_next.quot_two      = prod_two[stmc_pkg::DIV10_SHIFT +: stmc_pkg::QUOT_W];
    assign item_next.button_fwd    = button_fwd;
    assign item_next.button_rev    = button_rev;
    assign item_next.manual_toggle = manual_toggle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sun_offset    <= stmc_pkg::RST_SUN_OFFSET;
            cfg_reg.sun_threshold <= stmc_pkg::RST_SUN_THRESHOLD;
            cfg_reg.deadband      <= stmc_pkg::RST_DEADBAND;
            cfg_reg.settle_ms     <= stmc_pkg::RST_SETTLE_MS;
            cfg_reg.low_sun_ms    <= stmc_pkg::RST_LOW_SUN_MS;
            cfg_reg.track_ms      <= stmc_pkg::RST_TRACK_MS;
            cfg_reg.post_track_ms <= stmc_pkg::RST_POST_TRACK_MS;
            cfg_reg.return_ms     <= stmc_pkg::RST_RETURN_MS;
        end
        else if (cfg_we)
        begin
            case (stmc_pkg::reg_index_t'(cfg_index))
                stmc_pkg::REG_SUN_OFFSET:    cfg_reg.sun_offset    <= cfg_data[11:0];
                stmc_pkg::REG_SUN_THRESHOLD: cfg_reg.sun_threshold <= cfg_data[11:0];
                stmc_pkg::REG_DEADBAND:      cfg_reg.deadband      <= cfg_data[11:0];
                stmc_pkg::REG_SETTLE_MS:     cfg_reg.settle_ms     <= cfg_data;
                stmc_pkg::REG_LOW_SUN_MS:    cfg_reg.low_sun_ms    <= cfg_data;
                stmc_pkg::REG_TRACK_MS:      cfg_reg.track_ms      <= cfg_data;
                stmc_pkg::REG_POST_TRACK_MS: cfg_reg.post_track_ms <= cfg_data;
                stmc_pkg::REG_RETURN_MS:     cfg_reg.return_ms     <= cfg_data;
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_free)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            item_reg <= item_next;
        if (advance)
            result_reg <= result_next;
    end

    stmc_ctrl #(
        .TRACK_DUTY  (TRACK_DUTY),
        .MANUAL_DUTY (MANUAL_DUTY)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (result_next)
    );

    assign out_valid = out_valid_reg;
    assign drive_one = result_reg.drive_one;
    assign drive_two = result_reg.drive_two;
    assign mode      = result_reg.mode;

`ifndef ASSERT_OFF
    a_single_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (drive_one == '0 || drive_two == '0))
        else $error("both motor channels driven at once");

    a_drive_one_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && drive_one != '0) |->
        (mode == stmc_pkg::MODE_TRACK || mode == stmc_pkg::MODE_MANUAL))
        else $error("channel one driven outside tracking or manual");

    a_drive_two_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && drive_two != '0) |->
        (mode == stmc_pkg::MODE_TRACK || mode == stmc_pkg::MODE_RETURN ||
         mode == stmc_pkg::MODE_MANUAL))
        else $error("channel two driven outside a drive mode");
`endif

endmodule

// ----- test/solar_tracker_mode_controller_tb.sv -----
module solar_tracker_mode_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [stmc_pkg::DUTY_W-1:0] TRACK_DUTY  = 13'd5000;
    localparam logic [stmc_pkg::DUTY_W-1:0] MANUAL_DUTY = 13'd7000;
    localparam int                          SENS_MAX    = 32767;

    typedef struct packed {
        logic [stmc_pkg::SENS_W-1:0] sensor_one;
        logic [stmc_pkg::SENS_W-1:0] sensor_two;
        logic                        button_fwd;
        logic                        button_rev;
        logic                        manual_toggle;
    } tick_t;

    typedef struct packed {
        tick_t             tick;
        logic              typed;
        stmc_pkg::result_t want;
    } probe_row_t;

    // Opening rows run on the reset settings: sunny means sensor_one of 25599 or less.
    localparam int N_PROBES = 20;
    localparam probe_row_t PROBES [N_PROBES] = '{
        '{'{15'd0,     15'd0,     1'b0, 1'b0, 1'b0}, 1'b1,
          '{13'd0,    13'd0,    stmc_pkg::MODE_SUNNY}},
        '{'{15'd0,     15'd32767, 1'b1, 1'b1, 1'b0}, 1'b1,
          '{13'd0,    13'd0,    stmc_pkg::MODE_SUNNY}},
        '{'{15'd0,     15'd0,     1'b0, 1'b0, 1'b1}, 1'b1,
          '{13'd0,    13'd0,    stmc_pkg::MODE_MANUAL}},
        '{'{15'd32767, 15'd32767, 1'b1, 1'b0, 1'b0}, 1'b1,
          '{13'd7000, 13'd0,    stmc_pkg::MODE_MANUAL}},
        '{'{15'd0,     15'd0,     1'b0, 1'b1, 1'b0}, 1'b1,
          '{13'd0,    13'd7000, stmc_pkg::MODE_MANUAL}},
        '{'{15'd0,     15'd0,     1'b1, 1'b1, 1'b0}, 1'b1,
          '{13'd7000, 13'd0,    stmc_pkg::MODE_MANUAL}},
        '{'{15'd0,     15'd0,     1'b0, 1'b0, 1'b0}, 1'b1,
          '{13'd0,    13'd0,    stmc_pkg::MODE_MANUAL}},
        '{'{15'd0,     15'd0,     1'b1, 1'b1, 1'b1}, 1'b1,
          '{13'd0,    13'd0,    stmc_pkg::MODE_IDLE}},
        '{'{15'd32767, 15'd0,     1'b0, 1'b0, 1'b0}, 1'b1,
          '{13'd0,    13'd0,    stmc_pkg::MODE_WAIT}},
        '{'{15'd32767, 15'd0,     1'b0, 1'b0, 1'b0}, 1'b1,
          '{13'd0,    13'd0,    stmc_pkg::MODE_WAIT}},
        '{'{15'd25600, 15'd0,     1'b0, 1'b0, 1'b0}, 1'b1,
          '{13'd0,    13'd0,    stmc_pkg::MODE_WAIT}},
        '{'{15'd25599, 15'd0,     1'b0, 1'b0, 1'b0}, 1'b1,
          '{13'd0,    13'd0,    stmc_pkg::MODE_IDLE}},
        '{'{15'd25599, 15'd0,     1'b1, 1'b0, 1'b0}, 1'b1,
          '{13'd0,    13'd0,    stmc_pkg::MODE_SUNNY}},
        '{'{15'd0,     15'd0,     1'b0, 1'b0, 1'b1}, 1'b1,
          '{13'd0,    13'd0,    stmc_pkg::MODE_MANUAL}},
        '{'{15'd0,     15'd0,     1'b0, 1'b0, 1'b1}, 1'b1,
          '{13'd0,    13'd0,    stmc_pkg::MODE_IDLE}},
        '{'{15'd25600, 15'd0,     1'b0, 1'b0, 1'b0}, 1'b1,
          '{13'd0,    13'd0,    stmc_pkg::MODE_WAIT}},
        '{'{15'd0,     15'd0,     1'b0, 1'b0, 1'b1}, 1'b1,
          '{13'd0,    13'd0,    stmc_pkg::MODE_MANUAL}},
        '{'{15'd0,     15'd0,     1'b1, 1'b0, 1'b1}, 1'b1,
          '{13'd0,    13'd0,    stmc_pkg::MODE_IDLE}},
        '{'{15'd12345, 15'd6789,  1'b1, 1'b0, 1'b0}, 1'b0,
          '{13'd0,    13'd0,    stmc_pkg::MODE_IDLE}},
        '{'{15'd0,     15'd0,     1'b0, 1'b0, 1'b0}, 1'b0,
          '{13'd0,    13'd0,    stmc_pkg::MODE_IDLE}}
    };

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          in_valid      = 1'b0;
    logic                          in_stall;
    logic [stmc_pkg::SENS_W-1:0]   sensor_one    = '0;
    logic [stmc_pkg::SENS_W-1:0]   sensor_two    = '0;
    logic                          button_fwd    = 1'b0;
    logic                          button_rev    = 1'b0;
    logic                          manual_toggle = 1'b0;
    logic                          out_valid;
    logic                          out_stall     = 1'b0;
    logic [stmc_pkg::DUTY_W-1:0]   drive_one;
    logic [stmc_pkg::DUTY_W-1:0]   drive_two;
    logic [stmc_pkg::MODE_W-1:0]   mode;
    logic                          cfg_we        = 1'b0;
    logic [stmc_pkg::INDEX_W-1:0]  cfg_index     = stmc_pkg::REG_SUN_OFFSET;
    logic [stmc_pkg::CFG_W-1:0]    cfg_data      = '0;

    stmc_pkg::cfg_t              tracker_cfg;
    stmc_pkg::mode_t             tracker_mode;
    logic [stmc_pkg::TIME_W-1:0] tracker_ms;
    stmc_pkg::result_t           pending_results[$];
    int                          mismatches  = 0;
    int                          burst_left  = 0;
    int                          gap_max     = 0;
    int                          stall_level = 0;
    bit                          stall_on    = 1'b0;
    int                          stall_run   = 0;

    solar_tracker_mode_controller DUT (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit sun_up(input logic [stmc_pkg::SENS_W-1:0] reading);
        return (int'(tracker_cfg.sun_offset) - int'(reading) / 10) >
               int'(tracker_cfg.sun_threshold);
    endfunction

    function automatic void restart(input stmc_pkg::mode_t next_mode);
        tracker_mode = next_mode;
        tracker_ms   = '0;
    endfunction

    function automatic void count_ms();
        if (tracker_ms != stmc_pkg::TIME_MAX)
            tracker_ms = tracker_ms + 1'b1;
    endfunction

    task automatic advance_tracker(input tick_t t, output stmc_pkg::result_t r);
        int diff;
        int db;
        diff = int'(t.sensor_one) / 10 - int'(t.sensor_two) / 10;
        db   = int'(tracker_cfg.deadband);
        r.drive_one = '0;
        r.drive_two = '0;
        if (t.manual_toggle)
            restart(tracker_mode == stmc_pkg::MODE_MANUAL ? stmc_pkg::MODE_IDLE
                                                          : stmc_pkg::MODE_MANUAL);
        else
        begin
            case (tracker_mode)
                stmc_pkg::MODE_IDLE:
                    restart(sun_up(t.sensor_one) ? stmc_pkg::MODE_SUNNY
                                                 : stmc_pkg::MODE_WAIT);
                stmc_pkg::MODE_SUNNY:
                    if (tracker_ms >= tracker_cfg.settle_ms)
                        restart(sun_up(t.sensor_one) ? stmc_pkg::MODE_TRACK
                                                     : stmc_pkg::MODE_IDLE);
                    else
                        count_ms();
                stmc_pkg::MODE_TRACK:
                    if (tracker_ms >= tracker_cfg.track_ms)
                        restart(stmc_pkg::MODE_POST);
                    else
                    begin
                        if (diff > db || diff < -db)
                        begin
                            if (diff >= 0)
                                r.drive_one = TRACK_DUTY;
                            else
                                r.drive_two = TRACK_DUTY;
                        end
                        count_ms();
                    end
                stmc_pkg::MODE_POST:
                    if (tracker_ms >= tracker_cfg.post_track_ms)
                        restart(stmc_pkg::MODE_IDLE);
                    else
                        count_ms();
                stmc_pkg::MODE_WAIT:
                    if (sun_up(t.sensor_one))
                        restart(stmc_pkg::MODE_IDLE);
                    else if (tracker_ms >= tracker_cfg.low_sun_ms)
                        restart(stmc_pkg::MODE_RETURN);
                    else
                        count_ms();
                stmc_pkg::MODE_RETURN:
                    if (tracker_ms >= tracker_cfg.return_ms)
                        restart(stmc_pkg::MODE_IDLE);
                    else
                    begin
                        r.drive_two = TRACK_DUTY;
                        count_ms();
                    end
                stmc_pkg::MODE_MANUAL:
                    if (t.button_fwd)
                        r.drive_one = MANUAL_DUTY;
                    else if (t.button_rev)
                        r.drive_two = MANUAL_DUTY;
                default:
                    restart(stmc_pkg::MODE_IDLE);
            endcase
        end
        r.mode = tracker_mode;
    endtask

    function automatic int fit_sensor(input int v);
        if (v < 0)
            return 0;
        if (v > SENS_MAX)
            return SENS_MAX;
        return v;
    endfunction

    // Readings cluster round the sunny boundary and the deadband edges so that
    // the machine keeps crossing both.
    function automatic tick_t random_tick();
        tick_t t;
        int    bound;
        int    pick;
        int    one;
        int    two;
        int    spread;
        bound = fit_sensor((int'(tracker_cfg.sun_offset) -
                            int'(tracker_cfg.sun_threshold)) * 10);
        pick  = $urandom_range(0, 99);
        if (pick < 40)
            one = bound + int'($urandom_range(0, 40)) - 20;
        else if (pick < 65)
            one = $urandom_range(0, bound);
        else if (pick < 85)
            one = $urandom_range(bound, SENS_MAX);
        else
            one = $urandom_range(0, SENS_MAX);
        one = fit_sensor(one);
        if ($urandom_range(0, 1) == 0)
            two = $urandom_range(0, SENS_MAX);
        else
        begin
            spread = int'(tracker_cfg.deadband) * 10 + int'($urandom_range(0, 30)) - 15;
            two    = fit_sensor($urandom_range(0, 1) == 0 ? one + spread : one - spread);
        end
        t.sensor_one    = one[stmc_pkg::SENS_W-1:0];
        t.sensor_two    = two[stmc_pkg::SENS_W-1:0];
        t.button_fwd    = 1'($urandom_range(0, 1));
        t.button_rev    = 1'($urandom_range(0, 1));
        t.manual_toggle = ($urandom_range(0, 99) < 3);
        return t;
    endfunction

    function automatic stmc_pkg::cfg_t phase_setting(input int phase);
        stmc_pkg::cfg_t c;
        c.sun_offset    = 12'($urandom_range(1000, 4095));
        c.sun_threshold = 12'($urandom_range(0, 300));
        c.deadband      = 12'($urandom_range(0, 120));
        c.settle_ms     = 16'($urandom_range(0, 25));
        c.low_sun_ms    = 16'($urandom_range(0, 25));
        c.track_ms      = 16'($urandom_range(0, 25));
        c.post_track_ms = 16'($urandom_range(0, 25));
        c.return_ms     = 16'($urandom_range(0, 25));
        case (phase)
            1:
            begin
                c = '{12'd2580, 12'd20, 12'd10, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            end
            2:
            begin
                c = '{12'd4095, 12'd0, 12'd0, stmc_pkg::TIME_MAX, stmc_pkg::TIME_MAX,
                      stmc_pkg::TIME_MAX, stmc_pkg::TIME_MAX, stmc_pkg::TIME_MAX};
            end
            3:
            begin
                c.sun_offset    = 12'd0;
                c.sun_threshold = 12'd4095;
                c.deadband      = 12'd3276;
            end
            4:
            begin
                c.sun_offset    = 12'd4095;
                c.sun_threshold = 12'd0;
                c.deadband      = 12'd3276;
            end
            5:
            begin
                c.sun_offset    = 12'd0;
                c.sun_threshold = 12'd0;
                c.deadband      = 12'd0;
            end
            default:
            begin
            end
        endcase
        return c;
    endfunction

    task automatic write_reg(input stmc_pkg::reg_index_t index,
                             input logic [stmc_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_setting(input stmc_pkg::cfg_t c);
        write_reg(stmc_pkg::REG_SUN_OFFSET,    stmc_pkg::CFG_W'(c.sun_offset));
        write_reg(stmc_pkg::REG_SUN_THRESHOLD, stmc_pkg::CFG_W'(c.sun_threshold));
        write_reg(stmc_pkg::REG_DEADBAND,      stmc_pkg::CFG_W'(c.deadband));
        write_reg(stmc_pkg::REG_SETTLE_MS,     c.settle_ms);
        write_reg(stmc_pkg::REG_LOW_SUN_MS,    c.low_sun_ms);
        write_reg(stmc_pkg::REG_TRACK_MS,      c.track_ms);
        write_reg(stmc_pkg::REG_POST_TRACK_MS, c.post_track_ms);
        write_reg(stmc_pkg::REG_RETURN_MS,     c.return_ms);
        cfg_we      <= 1'b0;
        tracker_cfg  = c;
    endtask

    // Presents one tick and, once it is taken, queues what it should produce.
    task automatic send_tick(input tick_t t, input logic typed,
                             input stmc_pkg::result_t want);
        stmc_pkg::result_t r;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gap_max != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid      <= 1'b1;
        sensor_one    <= t.sensor_one;
        sensor_two    <= t.sensor_two;
        button_fwd    <= t.button_fwd;
        button_rev    <= t.button_rev;
        manual_toggle <= t.manual_toggle;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_tracker(t, r);
        pending_results.push_back(typed ? want : r);
    endtask

    // Before a register write every result must be out and the pipeline empty.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            if (stall_level == 0)
            begin
                stall_on  = 1'b0;
                stall_run = 16;
            end
            else
            begin
                stall_on  = !stall_on;
                stall_run = stall_on ? $urandom_range(1, stall_level == 1 ? 2 : 8)
                                     : $urandom_range(1, stall_level == 1 ? 12 : 4);
            end
        end
        else
            stall_run--;
        out_stall <= stall_on;
    end

    always @(posedge clk)
    begin : check_result
        stmc_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected transaction: drive_one %0d drive_two %0d mode %0d",
                       drive_one, drive_two, mode);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (drive_one !== want.drive_one)
                begin
                    $error("drive_one: expected %0d, got %0d", want.drive_one, drive_one);
                    mismatches++;
                end
                if (drive_two !== want.drive_two)
                begin
                    $error("drive_two: expected %0d, got %0d", want.drive_two, drive_two);
                    mismatches++;
                end
                if (mode !== want.mode)
                begin
                    $error("mode: expected %0d, got %0d", want.mode, mode);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("solar_tracker_mode_controller_tb: FAIL");
        $finish;
    end

    initial
    begin
        int phase;
        int n;
        tracker_cfg  = '{stmc_pkg::RST_SUN_OFFSET, stmc_pkg::RST_SUN_THRESHOLD,
                         stmc_pkg::RST_DEADBAND, stmc_pkg::RST_SETTLE_MS,
                         stmc_pkg::RST_LOW_SUN_MS, stmc_pkg::RST_TRACK_MS,
                         stmc_pkg::RST_POST_TRACK_MS, stmc_pkg::RST_RETURN_MS};
        tracker_mode = stmc_pkg::MODE_IDLE;
        tracker_ms   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_max     = 2;
        stall_level = 1;
        for (n = 0; n < N_PROBES; n++)
            send_tick(PROBES[n].tick, PROBES[n].typed, PROBES[n].want);

        // Phase 2 pins every timer at its maximum, so it is kept short.
        for (phase = 1; phase <= 11; phase++)
        begin
            drain();
            load_setting(phase_setting(phase));
            gap_max     = (phase % 3 == 0) ? 0 : (phase % 3 == 1 ? 3 : 8);
            stall_level = phase % 3;
            for (n = 0; n < (phase == 2 ? 40 : 105); n++)
                send_tick(random_tick(), 1'b0, '0);
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("solar_tracker_mode_controller_tb: PASS");
        else
            $display("solar_tracker_mode_controller_tb: FAIL");
        $finish;
    end

endmodule
